// ===== hdl/vpa_pkg.sv =====
package vpa_pkg;

  localparam int unsigned START_IDX_BITS = 6;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_LOAD    = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_FIRST = 2'd1;
  localparam logic [1:0] FIT_NEXT  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ADEC,
    S_SHUP,
    S_WR0,
    S_WR1,
    S_RMRG,
    S_SHDN,
    S_DONE
  } vpa_state_t;

endpackage

// ===== hdl/vpa_ram.sv =====
module vpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/variable_partition_allocator.sv =====
// Segment allocator over an address-ordered table held in one RAM.
// Channels: in_* carries requests (op in in_tuser), out_* carries one
// result per request (status in out_tuser), cfg_* writes fit_policy and is
// always ready; write it only while no request is in flight.
// A request is taken only when the sequencer is idle; the next request is
// accepted while the previous result still waits on out_tready.
// Load and clear go straight to the done state. Release and allocate
// scan every table entry; a release that merges a free neighbour then
// shifts the later entries down, and an allocate that splits a segment
// first shifts the later entries up by one.
// The next request is taken in the cycle after its result is registered.
// Every pass moves one table entry per cycle through the single RAM read
// port, so the entry scan and the shift passes dominate a request's run.
// Reset empties the table (entry count 0) and sets best fit; RAM contents
// need no clearing. A stalled receiver holds the result in the output
// register; a request finishing meanwhile waits in the done state.
module variable_partition_allocator #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ADDR_BITS   = 16,
  parameter int unsigned OWNER_BITS  = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // op
  input  logic [1:0] in_tuser,
  // req_size, owner_id, start_index, block_start, block_end, block_size
  input  logic [((4*ADDR_BITS+OWNER_BITS+vpa_pkg::START_IDX_BITS+2+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status
  output logic [1:0] out_tuser,
  // seg_start, seg_end, seg_size, seg_owner, entry_count
  output logic [((3*ADDR_BITS+OWNER_BITS+$clog2(TABLE_DEPTH+1)+1+7)/8)*8-1:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_data
);
  import vpa_pkg::*;

  localparam int unsigned A   = ADDR_BITS;
  localparam int unsigned ZW  = ADDR_BITS + 1;
  localparam int unsigned OW  = OWNER_BITS;
  localparam int unsigned SW  = START_IDX_BITS;
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW  = $clog2(TABLE_DEPTH);
  localparam int unsigned XW  = (CW > SW) ? CW : SW;
  localparam int unsigned EW  = 2*A + ZW + OW;
  localparam int unsigned OUW = ((3*A + OW + CW + 1 + 7) / 8) * 8;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [ZW-1:0] SZ_MAX  = ZW'(1) << A;

  function automatic logic [ZW-1:0] sat_add(input logic [ZW-1:0] x, input logic [ZW-1:0] y);
    logic [ZW:0] s;
    s = {1'b0, x} + {1'b0, y};
    sat_add = (s > {1'b0, SZ_MAX}) ? SZ_MAX : s[ZW-1:0];
  endfunction

  logic [ZW-1:0] i_req, i_bsize, bsize_sat;
  logic [OW-1:0] i_pid;
  logic [SW-1:0] i_sidx;
  logic [A-1:0]  i_bstart, i_bend;

  assign i_req    = in_tdata[ZW-1:0];
  assign i_pid    = in_tdata[ZW+OW-1:ZW];
  assign i_sidx   = in_tdata[ZW+OW+SW-1:ZW+OW];
  assign i_bstart = in_tdata[ZW+OW+SW+A-1:ZW+OW+SW];
  assign i_bend   = in_tdata[ZW+OW+SW+2*A-1:ZW+OW+SW+A];
  assign i_bsize  = in_tdata[2*ZW+OW+SW+2*A-1:ZW+OW+SW+2*A];
  assign bsize_sat = (i_bsize > SZ_MAX) ? SZ_MAX : i_bsize;

  vpa_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    policy_r, policy_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    o_status_r, o_status_nxt;
  logic [A-1:0]  o_start_r, o_start_nxt, o_end_r, o_end_nxt;
  logic [ZW-1:0] o_size_r, o_size_nxt;
  logic [OW-1:0] o_owner_r, o_owner_nxt;
  logic [CW-1:0] o_count_r, o_count_nxt;

  logic [1:0]    op_r, op_nxt;
  logic [ZW-1:0] req_r, req_nxt;
  logic [OW-1:0] pid_r, pid_nxt;
  logic [A-1:0]  bstart_r, bstart_nxt, bend_r, bend_nxt;

  logic [CW-1:0] ptr_r, ptr_nxt, cnt_r, cnt_nxt, didx_r, didx_nxt, k_r, k_nxt, rp_r, rp_nxt;
  logic          vld_r, vld_nxt, found_r, found_nxt;
  logic [A-1:0]  pk_s_r, pk_s_nxt, pk_e_r, pk_e_nxt;
  logic [ZW-1:0] pk_z_r, pk_z_nxt;
  logic [A-1:0]  pr_s_r, pr_s_nxt;
  logic [ZW-1:0] pr_z_r, pr_z_nxt;
  logic [OW-1:0] pr_o_r, pr_o_nxt;
  logic [A-1:0]  pv_s_r, pv_s_nxt;
  logic [ZW-1:0] pv_z_r, pv_z_nxt;
  logic          pv_free_r, pv_free_nxt;
  logic [A-1:0]  nx_e_r, nx_e_nxt;
  logic [ZW-1:0] nx_z_r, nx_z_nxt;
  logic          nx_free_r, nx_free_nxt, nx_have_r, nx_have_nxt;
  logic [1:0]    sh_r, sh_nxt;

  logic [1:0]    rs_status_r, rs_status_nxt;
  logic [A-1:0]  rs_start_r, rs_start_nxt, rs_end_r, rs_end_nxt;
  logic [ZW-1:0] rs_size_r, rs_size_nxt;
  logic [OW-1:0] rs_owner_r, rs_owner_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  vpa_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [A-1:0]  r_s, r_e;
  logic [ZW-1:0] r_z;
  logic [OW-1:0] r_o;
  assign r_s = ram_rdata[A-1:0];
  assign r_e = ram_rdata[2*A-1:A];
  assign r_z = ram_rdata[2*A+ZW-1:2*A];
  assign r_o = ram_rdata[EW-1:2*A+ZW];

  logic [A-1:0] new_end;
  assign new_end = A'(pk_s_r + req_r[A-1:0] - 1'b1);

  logic usable, take, nf;
  assign usable = (r_o == '0) && (r_z >= req_r);
  assign nf     = nx_have_r && nx_free_r;

  always_comb begin
    take = 1'b0;
    unique case (policy_r)
      FIT_BEST:  take = usable && (!found_r || r_z < pk_z_r);
      FIT_WORST: take = usable && (!found_r || r_z > pk_z_r);
      default:   take = usable && !found_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    policy_nxt    = policy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_start_nxt   = o_start_r;
    o_end_nxt     = o_end_r;
    o_size_nxt    = o_size_r;
    o_owner_nxt   = o_owner_r;
    o_count_nxt   = o_count_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    pid_nxt       = pid_r;
    bstart_nxt    = bstart_r;
    bend_nxt      = bend_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    didx_nxt      = didx_r;
    k_nxt         = k_r;
    rp_nxt        = rp_r;
    vld_nxt       = 1'b0;
    found_nxt     = found_r;
    pk_s_nxt      = pk_s_r;
    pk_e_nxt      = pk_e_r;
    pk_z_nxt      = pk_z_r;
    pr_s_nxt      = pr_s_r;
    pr_z_nxt      = pr_z_r;
    pr_o_nxt      = pr_o_r;
    pv_s_nxt      = pv_s_r;
    pv_z_nxt      = pv_z_r;
    pv_free_nxt   = pv_free_r;
    nx_e_nxt      = nx_e_r;
    nx_z_nxt      = nx_z_r;
    nx_free_nxt   = nx_free_r;
    nx_have_nxt   = nx_have_r;
    sh_nxt        = sh_r;
    rs_status_nxt = rs_status_r;
    rs_start_nxt  = rs_start_r;
    rs_end_nxt    = rs_end_r;
    rs_size_nxt   = rs_size_r;
    rs_owner_nxt  = rs_owner_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    in_tready     = (state_r == S_IDLE);

    if (cfg_valid) begin
      policy_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt        = in_tuser;
          req_nxt       = i_req;
          pid_nxt       = i_pid;
          bstart_nxt    = i_bstart;
          bend_nxt      = i_bend;
          rs_status_nxt = ST_OK;
          rs_start_nxt  = '0;
          rs_end_nxt    = '0;
          rs_size_nxt   = '0;
          rs_owner_nxt  = '0;
          found_nxt     = 1'b0;
          nx_have_nxt   = 1'b0;
          cnt_nxt       = '0;
          pr_o_nxt      = '0;
          ptr_nxt       = '0;
          unique case (in_tuser)
            OP_ALLOC: begin
              if (policy_r == FIT_NEXT && XW'(i_sidx) < XW'(count_r)) begin
                ptr_nxt = CW'(i_sidx);
              end
              state_nxt = S_SCAN;
            end
            OP_RELEASE: begin
              state_nxt = S_SCAN;
            end
            OP_LOAD: begin
              if (count_r == DEPTH_C) begin
                rs_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[IW-1:0];
                ram_wdata = {i_pid, bsize_sat, i_bend, i_bstart};
                count_nxt = count_r + 1'b1;
              end
              state_nxt = S_DONE;
            end
            default: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cnt_r != count_r) begin
          ram_raddr = ptr_r[IW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          vld_nxt   = 1'b1;
          didx_nxt  = ptr_r;
          ptr_nxt   = (CW'(ptr_r + 1'b1) == count_r) ? '0 : CW'(ptr_r + 1'b1);
        end
        if (vld_r) begin
          if (op_r == OP_ALLOC) begin
            if (take) begin
              found_nxt = 1'b1;
              k_nxt     = didx_r;
              pk_s_nxt  = r_s;
              pk_e_nxt  = r_e;
              pk_z_nxt  = r_z;
            end
          end else if (found_r) begin
            if (!nx_have_r) begin
              nx_have_nxt = 1'b1;
              nx_e_nxt    = r_e;
              nx_z_nxt    = r_z;
              nx_free_nxt = (r_o == '0);
            end
          end else if (r_s == bstart_r && r_e == bend_r && r_o == pid_r) begin
            found_nxt   = 1'b1;
            k_nxt       = didx_r;
            pk_s_nxt    = r_s;
            pk_e_nxt    = r_e;
            pk_z_nxt    = r_z;
            pv_s_nxt    = pr_s_r;
            pv_z_nxt    = pr_z_r;
            pv_free_nxt = (didx_r != '0) && (pr_o_r == '0);
          end else begin
            pr_s_nxt = r_s;
            pr_z_nxt = r_z;
            pr_o_nxt = r_o;
          end
        end
        if (cnt_r == count_r && !vld_r) begin
          state_nxt = (op_r == OP_ALLOC) ? S_ADEC : S_RMRG;
        end
      end

      S_ADEC: begin
        if (req_r == '0 || !found_r) begin
          rs_status_nxt = ST_NOFIT;
          state_nxt     = S_DONE;
        end else if (pk_z_r == req_r) begin
          ram_we       = 1'b1;
          ram_waddr    = k_r[IW-1:0];
          ram_wdata    = {pid_r, pk_z_r, pk_e_r, pk_s_r};
          rs_start_nxt = pk_s_r;
          rs_end_nxt   = pk_e_r;
          rs_size_nxt  = pk_z_r;
          rs_owner_nxt = pid_r;
          state_nxt    = S_DONE;
        end else if (count_r == DEPTH_C) begin
          rs_status_nxt = ST_FULL;
          state_nxt     = S_DONE;
        end else begin
          rs_start_nxt = pk_s_r;
          rs_end_nxt   = new_end;
          rs_size_nxt  = req_r;
          rs_owner_nxt = pid_r;
          rp_nxt       = count_r - 1'b1;
          state_nxt    = S_SHUP;
        end
      end

      S_SHUP: begin
        if (rp_r > k_r) begin
          ram_raddr = rp_r[IW-1:0];
          didx_nxt  = rp_r;
          vld_nxt   = 1'b1;
          rp_nxt    = rp_r - 1'b1;
        end
        if (vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(didx_r + 1'b1);
          ram_wdata = ram_rdata;
        end
        if (!(rp_r > k_r) && !vld_r) begin
          state_nxt = S_WR0;
        end
      end

      S_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        ram_wdata = {pid_r, req_r, new_end, pk_s_r};
        state_nxt = S_WR1;
      end

      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(k_r + 1'b1);
        ram_wdata = {OW'(0), ZW'(pk_z_r - req_r), pk_e_r, A'(new_end + 1'b1)};
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end

      S_RMRG: begin
        if (!found_r) begin
          rs_status_nxt = ST_NOMATCH;
          state_nxt     = S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pv_free_r ? IW'(k_r - 1'b1) : k_r[IW-1:0];
          ram_wdata = {OW'(0),
                       sat_add(pv_free_r ? sat_add(pv_z_r, pk_z_r) : pk_z_r,
                               nf ? nx_z_r : ZW'(0)),
                       nf ? nx_e_r : pk_e_r,
                       pv_free_r ? pv_s_r : pk_s_r};
          sh_nxt    = {1'b0, pv_free_r} + {1'b0, nf};
          rp_nxt    = k_r + 1'b1 + CW'(nf);
          state_nxt = (pv_free_r || nf) ? S_SHDN : S_DONE;
        end
      end

      S_SHDN: begin
        if (rp_r < count_r) begin
          ram_raddr = rp_r[IW-1:0];
          didx_nxt  = rp_r;
          vld_nxt   = 1'b1;
          rp_nxt    = rp_r + 1'b1;
        end
        if (vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(didx_r - CW'(sh_r));
          ram_wdata = ram_rdata;
        end
        if (!(rp_r < count_r) && !vld_r) begin
          count_nxt = count_r - CW'(sh_r);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = rs_status_r;
          o_start_nxt   = rs_start_r;
          o_end_nxt     = rs_end_r;
          o_size_nxt    = rs_size_r;
          o_owner_nxt   = rs_owner_r;
          o_count_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      policy_r    <= FIT_BEST;
      out_valid_r <= 1'b0;
      vld_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      policy_r    <= policy_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_status_r  <= o_status_nxt;
    o_start_r   <= o_start_nxt;
    o_end_r     <= o_end_nxt;
    o_size_r    <= o_size_nxt;
    o_owner_r   <= o_owner_nxt;
    o_count_r   <= o_count_nxt;
    op_r        <= op_nxt;
    req_r       <= req_nxt;
    pid_r       <= pid_nxt;
    bstart_r    <= bstart_nxt;
    bend_r      <= bend_nxt;
    ptr_r       <= ptr_nxt;
    cnt_r       <= cnt_nxt;
    didx_r      <= didx_nxt;
    k_r         <= k_nxt;
    rp_r        <= rp_nxt;
    found_r     <= found_nxt;
    pk_s_r      <= pk_s_nxt;
    pk_e_r      <= pk_e_nxt;
    pk_z_r      <= pk_z_nxt;
    pr_s_r      <= pr_s_nxt;
    pr_z_r      <= pr_z_nxt;
    pr_o_r      <= pr_o_nxt;
    pv_s_r      <= pv_s_nxt;
    pv_z_r      <= pv_z_nxt;
    pv_free_r   <= pv_free_nxt;
    nx_e_r      <= nx_e_nxt;
    nx_z_r      <= nx_z_nxt;
    nx_free_r   <= nx_free_nxt;
    nx_have_r   <= nx_have_nxt;
    sh_r        <= sh_nxt;
    rs_status_r <= rs_status_nxt;
    rs_start_r  <= rs_start_nxt;
    rs_end_r    <= rs_end_nxt;
    rs_size_r   <= rs_size_nxt;
    rs_owner_r  <= rs_owner_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = OUW'({o_count_r, o_owner_r, o_size_r, o_end_r, o_start_r});

endmodule
